### hdl/ppu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, constants and helpers shared by the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int NumParticles = 64;
    localparam int SlotW        = 6;
    localparam int CntW         = 7;
    localparam int PosW         = 20;
    localparam int LifeW        = 17;
    localparam int ShadeW       = 7;
    localparam int DtW          = 16;
    localparam int JitW         = 8;
    localparam int AdecW        = 18;
    localparam int ProdW        = PosW + DtW + 1;

    localparam logic [CntW-1:0]  NumCnt   = CntW'(NumParticles);
    localparam logic [CntW-1:0]  LastCnt  = CntW'(NumParticles - 1);
    localparam logic [SlotW-1:0] LastSlot = SlotW'(NumParticles - 1);

    localparam logic [LifeW-1:0] OneQ16 = 17'h10000;

    localparam logic signed [PosW+1:0] SatHi = 22'sd524287;
    localparam logic signed [PosW+1:0] SatLo = -22'sd524288;

    localparam logic CmdSpawn = 1'b0;
    localparam logic CmdTick  = 1'b1;

    localparam logic RegVelX = 1'b0;
    localparam logic RegVelY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic                   command;
        logic signed [PosW-1:0] emitter_x;
        logic signed [PosW-1:0] emitter_y;
        logic signed [JitW-1:0] jitter;
        logic [ShadeW-1:0]      shade;
        logic [DtW-1:0]         dt;
    } t_item;

    typedef struct packed {
        logic [SlotW-1:0]       slot;
        logic                   live;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic [LifeW-1:0]       alpha;
        logic [ShadeW-1:0]      gray;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [LifeW-1:0]       life;
        logic [LifeW-1:0]       alpha;
        logic signed [PosW-1:0] x;
        logic signed [PosW-1:0] y;
        logic signed [PosW-1:0] vx;
        logic signed [PosW-1:0] vy;
        logic [ShadeW-1:0]      gray;
    } t_entry;

    typedef struct packed {
        logic             valid;
        logic [SlotW-1:0] slot;
        logic             live;
        logic             last;
        t_entry           entry;
    } t_upd;

    function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
        logic signed [PosW-1:0] r;
        if (v > SatHi) begin
            r = SatHi[PosW-1:0];
        end else if (v < SatLo) begin
            r = SatLo[PosW-1:0];
        end else begin
            r = v[PosW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/particle_pool_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with round-robin respawn and per-frame aging.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item's final result has been issued. All particle state sits in one
// memory read one slot per cycle, so the single read port sets the timing.
// A spawn reads slots from the slot last spawned into (slot 0 after reset
// or a miss) onward, wrapping around; with 1 to 64 slots examined it issues
// one result. A tick streams 64 results on consecutive cycles, slot 0
// first, and no new item is taken until its last result is out. Results
// are strobed for one cycle on o_result_valid and cannot be held off. No
// clearing pass is needed after reset. The user must write velocity
// registers with i_cfg_we only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module particle_pool_update (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire ppu_pkg::t_item           i_item,
    output logic                          o_result_valid,
    output ppu_pkg::t_result              o_result,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_index,
    input  wire logic [ppu_pkg::PosW-1:0] i_cfg_data
);

    ppu_pkg::t_state                  r_state;
    ppu_pkg::t_state                  n_state;

    ppu_pkg::t_item                   r_item;
    logic signed [ppu_pkg::PosW-1:0]  r_spawn_x;
    logic signed [ppu_pkg::PosW-1:0]  r_spawn_y;
    logic signed [ppu_pkg::PosW-1:0]  r_vel_x;
    logic signed [ppu_pkg::PosW-1:0]  r_vel_y;
    logic [ppu_pkg::SlotW-1:0]        r_search_start;

    logic [ppu_pkg::CntW-1:0]         r_iss_cnt;
    logic [ppu_pkg::SlotW-1:0]        r_rd_addr;
    logic                             r_p1_valid;
    logic [ppu_pkg::SlotW-1:0]        r_p1_slot;
    logic                             r_p1_last;

    logic                             r_out_valid;
    ppu_pkg::t_result                 r_out;

    logic                             accept;
    logic                             issue;
    logic                             p1_chk;
    logic                             found;
    logic                             miss;
    logic                             spawn_stop;
    logic                             tick_in;

    ppu_pkg::t_entry                  rd_data;
    ppu_pkg::t_entry                  spawn_entry;
    ppu_pkg::t_upd                    upd;
    logic                             mem_we;
    logic [ppu_pkg::SlotW-1:0]        mem_wr_addr;
    ppu_pkg::t_entry                  mem_wr_data;

    ppu_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_re      (issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    ppu_tick u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tick_in),
        .i_slot  (r_p1_slot),
        .i_last  (r_p1_last),
        .i_entry (rd_data),
        .i_dt    (r_item.dt),
        .o_upd   (upd)
    );

    assign accept     = start && !busy;
    assign p1_chk     = (r_state == ppu_pkg::ST_SPAWN) && r_p1_valid;
    assign found      = p1_chk && (rd_data.life == '0);
    assign miss       = p1_chk && (rd_data.life != '0) && r_p1_last;
    assign spawn_stop = found || miss;
    assign tick_in    = (r_state == ppu_pkg::ST_TICK) && r_p1_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.command == ppu_pkg::CmdTick)
                            ? ppu_pkg::ST_TICK : ppu_pkg::ST_SPAWN;
                end
            end
            ppu_pkg::ST_SPAWN: begin
                if (spawn_stop) begin
                    n_state = ppu_pkg::ST_IDLE;
                end
            end
            ppu_pkg::ST_TICK: begin
                if (upd.valid && upd.last) begin
                    n_state = ppu_pkg::ST_IDLE;
                end
            end
            default: n_state = ppu_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b1;
        issue = 1'b0;
        case (r_state)
            ppu_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            ppu_pkg::ST_SPAWN: begin
                issue = !spawn_stop && (r_iss_cnt < ppu_pkg::NumCnt);
            end
            ppu_pkg::ST_TICK: begin
                issue = (r_iss_cnt < ppu_pkg::NumCnt);
            end
            default: begin
                busy  = 1'b1;
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        spawn_entry.life  = ppu_pkg::OneQ16;
        spawn_entry.alpha = ppu_pkg::OneQ16;
        spawn_entry.x     = r_spawn_x;
        spawn_entry.y     = r_spawn_y;
        spawn_entry.vx    = r_vel_x;
        spawn_entry.vy    = r_vel_y;
        spawn_entry.gray  = r_item.shade;
    end

    assign mem_we      = found || upd.valid;
    assign mem_wr_addr = found ? r_p1_slot : upd.slot;
    assign mem_wr_data = found ? spawn_entry : upd.entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ppu_pkg::ST_IDLE;
            r_vel_x        <= '0;
            r_vel_y        <= '0;
            r_search_start <= '0;
            r_iss_cnt      <= '0;
            r_rd_addr      <= '0;
            r_p1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p1_valid  <= issue;
            r_out_valid <= found || miss || upd.valid;
            if (i_cfg_we) begin
                if (i_cfg_index == ppu_pkg::RegVelX) begin
                    r_vel_x <= i_cfg_data;
                end else begin
                    r_vel_y <= i_cfg_data;
                end
            end
            if (accept) begin
                r_iss_cnt <= '0;
                r_rd_addr <= (i_item.command == ppu_pkg::CmdTick) ? '0 : r_search_start;
            end else if (issue) begin
                r_iss_cnt <= r_iss_cnt + 1'b1;
                r_rd_addr <= (r_rd_addr == ppu_pkg::LastSlot) ? '0 : r_rd_addr + 1'b1;
            end
            if (found) begin
                r_search_start <= r_p1_slot;
            end else if (miss) begin
                r_search_start <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_item;
            r_spawn_x <= ppu_pkg::sat_pos(
                {{2{i_item.emitter_x[ppu_pkg::PosW-1]}}, i_item.emitter_x}
                + {{(ppu_pkg::PosW+2-ppu_pkg::JitW){i_item.jitter[ppu_pkg::JitW-1]}},
                   i_item.jitter});
            r_spawn_y <= ppu_pkg::sat_pos(
                {{2{i_item.emitter_y[ppu_pkg::PosW-1]}}, i_item.emitter_y}
                + {{(ppu_pkg::PosW+2-ppu_pkg::JitW){i_item.jitter[ppu_pkg::JitW-1]}},
                   i_item.jitter});
        end
        if (issue) begin
            r_p1_slot <= r_rd_addr;
            r_p1_last <= (r_iss_cnt == ppu_pkg::LastCnt);
        end
        if (found) begin
            r_out.slot  <= r_p1_slot;
            r_out.live  <= 1'b1;
            r_out.pos_x <= r_spawn_x;
            r_out.pos_y <= r_spawn_y;
            r_out.alpha <= ppu_pkg::OneQ16;
            r_out.gray  <= r_item.shade;
            r_out.last  <= 1'b1;
        end else if (miss) begin
            r_out.slot  <= '0;
            r_out.live  <= 1'b0;
            r_out.pos_x <= '0;
            r_out.pos_y <= '0;
            r_out.alpha <= '0;
            r_out.gray  <= '0;
            r_out.last  <= 1'b1;
        end else if (upd.valid) begin
            r_out.slot  <= upd.slot;
            r_out.live  <= upd.live;
            r_out.pos_x <= upd.entry.x;
            r_out.pos_y <= upd.entry.y;
            r_out.alpha <= upd.entry.alpha;
            r_out.gray  <= upd.entry.gray;
            r_out.last  <= upd.last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule
`default_nettype wire

### hdl/ppu_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_mem
// Particle state memory: one write port, one read port with registered data.
// Per-slot valid bits make unwritten slots read as zero (dead).
// ----------------------------------------------------------------------------
module ppu_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_we,
    input  wire logic [ppu_pkg::SlotW-1:0] i_wr_addr,
    input  wire ppu_pkg::t_entry           i_wr_data,
    input  wire logic                      i_re,
    input  wire logic [ppu_pkg::SlotW-1:0] i_rd_addr,
    output ppu_pkg::t_entry                o_rd_data
);

    ppu_pkg::t_entry                     r_mem [ppu_pkg::NumParticles];
    logic [ppu_pkg::NumParticles-1:0]    r_vld;
    ppu_pkg::t_entry                     r_rd_data;
    logic                                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

### hdl/ppu_tick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_tick
// Per-slot aging datapath: life decrement and velocity products registered,
// then rounding, position move, alpha decay and saturation.
// ----------------------------------------------------------------------------
module ppu_tick (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [ppu_pkg::SlotW-1:0] i_slot,
    input  wire logic                      i_last,
    input  wire ppu_pkg::t_entry           i_entry,
    input  wire logic [ppu_pkg::DtW-1:0]   i_dt,
    output ppu_pkg::t_upd                  o_upd
);

    logic [ppu_pkg::LifeW-1:0]        n_life;
    logic [ppu_pkg::AdecW:0]          n_adec_sum;
    ppu_pkg::t_entry                  n_entry;

    logic                             r_valid;
    logic [ppu_pkg::SlotW-1:0]        r_slot;
    logic                             r_last;
    logic                             r_live;
    ppu_pkg::t_entry                  r_entry;
    logic signed [ppu_pkg::ProdW-1:0] r_prod_x;
    logic signed [ppu_pkg::ProdW-1:0] r_prod_y;
    logic [ppu_pkg::AdecW-1:0]        r_adec;

    logic signed [ppu_pkg::ProdW:0]   rnd_x;
    logic signed [ppu_pkg::ProdW:0]   rnd_y;
    logic signed [ppu_pkg::PosW+1:0]  dx;
    logic signed [ppu_pkg::PosW+1:0]  dy;
    logic signed [ppu_pkg::PosW+1:0]  mv_x;
    logic signed [ppu_pkg::PosW+1:0]  mv_y;
    logic [ppu_pkg::LifeW-1:0]        alpha_new;
    ppu_pkg::t_entry                  upd_entry;

    assign n_life = (i_entry.life > ppu_pkg::LifeW'(i_dt))
                  ? i_entry.life - ppu_pkg::LifeW'(i_dt) : '0;
    // 2.5*dt rounded half up
    assign n_adec_sum = ({3'b000, i_dt} << 2) + ppu_pkg::AdecW'(i_dt) + 19'd1;

    always_comb begin
        n_entry      = i_entry;
        n_entry.life = n_life;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_slot     <= i_slot;
            r_last     <= i_last;
            r_live     <= (n_life != '0);
            r_entry    <= n_entry;
            r_prod_x   <= i_entry.vx * $signed({1'b0, i_dt});
            r_prod_y   <= i_entry.vy * $signed({1'b0, i_dt});
            r_adec     <= n_adec_sum[ppu_pkg::AdecW:1];
        end
    end

    assign rnd_x = {r_prod_x[ppu_pkg::ProdW-1], r_prod_x} + 38'sd32768;
    assign rnd_y = {r_prod_y[ppu_pkg::ProdW-1], r_prod_y} + 38'sd32768;
    assign dx    = rnd_x[ppu_pkg::ProdW:16];
    assign dy    = rnd_y[ppu_pkg::ProdW:16];
    assign mv_x  = {{2{r_entry.x[ppu_pkg::PosW-1]}}, r_entry.x} - dx;
    assign mv_y  = {{2{r_entry.y[ppu_pkg::PosW-1]}}, r_entry.y} - dy;

    assign alpha_new = ({1'b0, r_entry.alpha} > r_adec)
                     ? ppu_pkg::LifeW'({1'b0, r_entry.alpha} - r_adec) : '0;

    always_comb begin
        upd_entry = r_entry;
        if (r_live) begin
            upd_entry.x     = ppu_pkg::sat_pos(mv_x);
            upd_entry.y     = ppu_pkg::sat_pos(mv_y);
            upd_entry.alpha = alpha_new;
        end
    end

    assign o_upd.valid = r_valid;
    assign o_upd.slot  = r_slot;
    assign o_upd.live  = r_live;
    assign o_upd.last  = r_last;
    assign o_upd.entry = upd_entry;

endmodule
`default_nettype wire
